@@ design/http_request_header_parser_unit_macros.svh @@
// assertion macros for the request header parser
`ifndef HTTP_REQUEST_HEADER_PARSER_UNIT_MACROS_SVH
`define HTTP_REQUEST_HEADER_PARSER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define HRP_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define HRP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/hrp_pkg.sv @@
// shared types, codes and method tables for the request header parser
package hrp_pkg;

    localparam int VERSION_BYTES      = 4;
    localparam logic [7:0] TARGET_LIMIT_RESET = 8'd200;

    localparam logic [7:0] CHAR_SP = 8'h20;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    localparam logic [1:0] KIND_TARGET  = 2'd0;
    localparam logic [1:0] KIND_VERSION = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;

    localparam logic [1:0] ST_FINE   = 2'd0;
    localparam logic [1:0] ST_BAD    = 2'd1;
    localparam logic [1:0] ST_LONG   = 2'd2;
    localparam logic [1:0] ST_NOIMPL = 2'd3;

    localparam int NUM_METHODS = 7;
    localparam logic [2:0] METHOD_GET     = 3'd0;
    localparam logic [2:0] METHOD_HEAD    = 3'd1;
    localparam logic [2:0] METHOD_POST    = 3'd2;
    localparam logic [2:0] METHOD_PUT     = 3'd3;
    localparam logic [2:0] METHOD_DELETE  = 3'd4;
    localparam logic [2:0] METHOD_CONNECT = 3'd5;
    localparam logic [2:0] METHOD_PATCH   = 3'd6;
    localparam logic [2:0] METHOD_OTHER   = 3'd7;

    localparam logic [2:0] VPREFIX_LEN = 3'd5;

    typedef struct packed {
        logic [1:0]  item_kind;
        logic [7:0]  data_byte;
        logic [7:0]  byte_index;
        logic [2:0]  method_code;
        logic [1:0]  parse_status;
        logic        header_complete;
        logic [15:0] header_length;
        logic        last_of_run;
    } hrp_item_t;

    function automatic logic [2:0] method_len(input logic [2:0] m);
        logic [2:0] len;
        case (m)
            METHOD_GET:     len = 3'd3;
            METHOD_HEAD:    len = 3'd4;
            METHOD_POST:    len = 3'd4;
            METHOD_PUT:     len = 3'd3;
            METHOD_DELETE:  len = 3'd6;
            METHOD_CONNECT: len = 3'd7;
            METHOD_PATCH:   len = 3'd5;
            default:        len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] method_char(input logic [2:0] m, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        case (m)
            METHOD_GET:
            begin
                case (pos)
                    3'd0:    c = "G";
                    3'd1:    c = "E";
                    3'd2:    c = "T";
                    default: c = 8'h00;
                endcase
            end
            METHOD_HEAD:
            begin
                case (pos)
                    3'd0:    c = "H";
                    3'd1:    c = "E";
                    3'd2:    c = "A";
                    3'd3:    c = "D";
                    default: c = 8'h00;
                endcase
            end
            METHOD_POST:
            begin
                case (pos)
                    3'd0:    c = "P";
                    3'd1:    c = "O";
                    3'd2:    c = "S";
                    3'd3:    c = "T";
                    default: c = 8'h00;
                endcase
            end
            METHOD_PUT:
            begin
                case (pos)
                    3'd0:    c = "P";
                    3'd1:    c = "U";
                    3'd2:    c = "T";
                    default: c = 8'h00;
                endcase
            end
            METHOD_DELETE:
            begin
                case (pos)
                    3'd0:    c = "D";
                    3'd1:    c = "E";
                    3'd2:    c = "L";
                    3'd3:    c = "E";
                    3'd4:    c = "T";
                    3'd5:    c = "E";
                    default: c = 8'h00;
                endcase
            end
            METHOD_CONNECT:
            begin
                case (pos)
                    3'd0:    c = "C";
                    3'd1:    c = "O";
                    3'd2:    c = "N";
                    3'd3:    c = "N";
                    3'd4:    c = "E";
                    3'd5:    c = "C";
                    3'd6:    c = "T";
                    default: c = 8'h00;
                endcase
            end
            METHOD_PATCH:
            begin
                case (pos)
                    3'd0:    c = "P";
                    3'd1:    c = "A";
                    3'd2:    c = "T";
                    3'd3:    c = "C";
                    3'd4:    c = "H";
                    default: c = 8'h00;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] vprefix_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = "H";
            3'd1:    c = "T";
            3'd2:    c = "T";
            3'd3:    c = "P";
            3'd4:    c = "/";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

@@ design/hrp_parse_core.sv @@
// per-byte parse state machine: state update and up to two result words
module hrp_parse_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_wdata,
    input  logic              in_accept,
    input  logic [7:0]        in_byte,
    input  logic              in_eor,
    output logic              push0,
    output logic              push1,
    output hrp_pkg::hrp_item_t item0,
    output hrp_pkg::hrp_item_t item1
);
    import hrp_pkg::*;

    typedef enum logic [3:0] {
        PH_METHOD,
        PH_SPACE,
        PH_TGT_FIRST,
        PH_TARGET,
        PH_VPREFIX,
        PH_VERSION,
        PH_LINE_LF,
        PH_LINE_START,
        PH_HDR_LINE,
        PH_FINAL_LF,
        PH_DONE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [6:0]  cand_reg, cand_next;
    logic [2:0]  mpos_reg, mpos_next;
    logic [2:0]  mfound_reg, mfound_next;
    logic [7:0]  fcount_reg, fcount_next;
    logic [1:0]  status_reg, status_next;
    logic [15:0] seen_reg, seen_next;
    logic        vsent_reg, vsent_next;
    logic [7:0]  max_len_reg;

    logic [6:0]  keep;
    logic        byte_emit;
    logic [1:0]  byte_kind;
    logic [7:0]  byte_idx;
    logic        verdict_emit;
    logic [1:0]  verdict_status;
    logic        verdict_complete;
    logic [2:0]  verdict_method;
    hrp_item_t   byte_item;
    hrp_item_t   verdict_item;

    always_comb
    begin
        phase_next       = phase_reg;
        cand_next        = cand_reg;
        mpos_next        = mpos_reg;
        mfound_next      = mfound_reg;
        fcount_next      = fcount_reg;
        status_next      = status_reg;
        vsent_next       = vsent_reg;
        seen_next        = (seen_reg != 16'hFFFF) ? seen_reg + 16'd1 : seen_reg;
        keep             = '0;
        byte_emit        = 1'b0;
        byte_kind        = KIND_TARGET;
        byte_idx         = fcount_reg;
        verdict_emit     = 1'b0;
        verdict_status   = ST_FINE;
        verdict_complete = 1'b0;

        for (int m = 0; m < NUM_METHODS; m++)
        begin
            keep[m] = cand_reg[m] && (mpos_reg < method_len(3'(m)))
                      && (method_char(3'(m), mpos_reg) == in_byte);
        end

        case (phase_reg)
            PH_METHOD:
            begin
                cand_next = keep;
                if (keep == '0)
                begin
                    mfound_next    = METHOD_OTHER;
                    verdict_emit   = 1'b1;
                    verdict_status = ST_NOIMPL;
                end
                else
                begin
                    // a full match moves on; the highest matching code wins
                    for (int m = 0; m < NUM_METHODS; m++)
                    begin
                        if (keep[m] && ({1'b0, method_len(3'(m))} == {1'b0, mpos_reg} + 4'd1))
                        begin
                            mfound_next = 3'(m);
                            phase_next  = PH_SPACE;
                        end
                    end
                    mpos_next = mpos_reg + 3'd1;
                end
            end
            PH_SPACE:
            begin
                if (in_byte == CHAR_SP)
                begin
                    phase_next = PH_TGT_FIRST;
                end
                else
                begin
                    verdict_emit   = 1'b1;
                    verdict_status = ST_BAD;
                end
            end
            PH_TGT_FIRST, PH_TARGET:
            begin
                if (in_byte == CHAR_SP)
                begin
                    if (phase_reg == PH_TGT_FIRST)
                    begin
                        verdict_emit   = 1'b1;
                        verdict_status = ST_BAD;
                    end
                    else
                    begin
                        phase_next = PH_VPREFIX;
                        mpos_next  = 3'd0;
                    end
                end
                else
                begin
                    phase_next = PH_TARGET;
                    if (fcount_reg < max_len_reg)
                    begin
                        byte_emit   = 1'b1;
                        byte_kind   = KIND_TARGET;
                        fcount_next = fcount_reg + 8'd1;
                    end
                    else
                    begin
                        // overlong target: drop the byte, keep scanning
                        status_next = ST_LONG;
                    end
                end
            end
            PH_VPREFIX:
            begin
                if ((mpos_reg < VPREFIX_LEN) && (vprefix_char(mpos_reg) == in_byte))
                begin
                    mpos_next = mpos_reg + 3'd1;
                    if (mpos_next == VPREFIX_LEN)
                    begin
                        phase_next  = PH_VERSION;
                        fcount_next = 8'd0;
                    end
                end
                else
                begin
                    verdict_emit   = 1'b1;
                    verdict_status = ST_BAD;
                end
            end
            PH_VERSION:
            begin
                if (in_byte == CHAR_CR)
                begin
                    phase_next = PH_LINE_LF;
                end
                else if (fcount_reg < 8'(VERSION_BYTES))
                begin
                    byte_emit   = 1'b1;
                    byte_kind   = KIND_VERSION;
                    fcount_next = fcount_reg + 8'd1;
                end
            end
            PH_LINE_LF:
            begin
                if (in_byte == CHAR_LF)
                begin
                    phase_next = PH_LINE_START;
                end
                else
                begin
                    verdict_emit   = 1'b1;
                    verdict_status = ST_BAD;
                end
            end
            PH_LINE_START:
            begin
                phase_next = (in_byte == CHAR_CR) ? PH_FINAL_LF : PH_HDR_LINE;
            end
            PH_HDR_LINE:
            begin
                if (in_byte == CHAR_CR)
                begin
                    phase_next = PH_LINE_LF;
                end
            end
            PH_FINAL_LF:
            begin
                verdict_emit = 1'b1;
                if (in_byte == CHAR_LF)
                begin
                    verdict_status   = status_reg;
                    verdict_complete = 1'b1;
                end
                else
                begin
                    verdict_status = ST_BAD;
                end
            end
            default:
            begin
            end
        endcase

        if (verdict_emit)
        begin
            vsent_next = 1'b1;
            phase_next = PH_DONE;
        end

        // end of buffer closes the request with a verdict if none went out
        if (in_eor && !vsent_next)
        begin
            verdict_emit     = 1'b1;
            verdict_complete = 1'b0;
            if (phase_next == PH_METHOD)
            begin
                mfound_next    = METHOD_OTHER;
                verdict_status = ST_NOIMPL;
            end
            else
            begin
                verdict_status = ST_BAD;
            end
        end

        verdict_method = mfound_next;

        if (in_eor)
        begin
            phase_next  = PH_METHOD;
            cand_next   = '1;
            mpos_next   = 3'd0;
            mfound_next = METHOD_OTHER;
            fcount_next = 8'd0;
            status_next = ST_FINE;
            seen_next   = 16'd0;
            vsent_next  = 1'b0;
        end
    end

    always_comb
    begin
        byte_item                 = '0;
        byte_item.item_kind       = byte_kind;
        byte_item.data_byte       = in_byte;
        byte_item.byte_index      = byte_idx;
        byte_item.method_code     = mfound_reg;

        verdict_item                 = '0;
        verdict_item.item_kind       = KIND_VERDICT;
        verdict_item.method_code     = verdict_method;
        verdict_item.parse_status    = verdict_status;
        verdict_item.header_complete = verdict_complete;
        verdict_item.header_length   = verdict_complete ?
                                       ((seen_reg != 16'hFFFF) ? seen_reg + 16'd1 : seen_reg)
                                       : 16'd0;
        verdict_item.last_of_run     = 1'b1;
    end

    assign push0 = in_accept && (byte_emit || verdict_emit);
    assign push1 = in_accept && byte_emit && verdict_emit;
    assign item0 = byte_emit ? byte_item : verdict_item;
    assign item1 = verdict_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_METHOD;
            cand_reg    <= '1;
            mpos_reg    <= 3'd0;
            mfound_reg  <= METHOD_OTHER;
            fcount_reg  <= 8'd0;
            status_reg  <= ST_FINE;
            seen_reg    <= 16'd0;
            vsent_reg   <= 1'b0;
            max_len_reg <= TARGET_LIMIT_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                max_len_reg <= cfg_wdata;
            end
            if (in_accept)
            begin
                phase_reg  <= phase_next;
                cand_reg   <= cand_next;
                mpos_reg   <= mpos_next;
                mfound_reg <= mfound_next;
                fcount_reg <= fcount_next;
                status_reg <= status_next;
                seen_reg   <= seen_next;
                vsent_reg  <= vsent_next;
            end
        end
    end

endmodule

@@ design/hrp_out_fifo.sv @@
// result queue taking up to two words per cycle and giving one
module hrp_out_fifo
#(
    parameter int DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push0,
    input  logic              push1,
    input  hrp_pkg::hrp_item_t din0,
    input  hrp_pkg::hrp_item_t din1,
    input  logic              pop,
    output hrp_pkg::hrp_item_t dout,
    output logic              not_empty,
    output logic              room_for_two
);
    import hrp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(DEPTH - 2);

    hrp_item_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [PTR_W-1:0] wr_ptr_inc1;
    logic [PTR_W-1:0] wr_ptr_inc2;

    assign wr_ptr_inc1 = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
    assign wr_ptr_inc2 = (wr_ptr_inc1 == LAST_PTR) ? '0 : wr_ptr_inc1 + PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        if (push1)
        begin
            wr_ptr_next = wr_ptr_inc2;
        end
        else if (push0)
        begin
            wr_ptr_next = wr_ptr_inc1;
        end
        rd_ptr_next = rd_ptr_reg;
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        cnt_next = cnt_reg + CNT_W'(push0) + CNT_W'(push1) - CNT_W'(pop);
    end

    assign dout         = mem_reg[rd_ptr_reg];
    assign not_empty    = (cnt_reg != '0);
    assign room_for_two = (cnt_reg <= ROOM_MAX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            mem_reg[wr_ptr_reg] <= din0;
        end
        if (push1)
        begin
            mem_reg[wr_ptr_inc1] <= din1;
        end
    end

endmodule

@@ design/http_request_header_parser_unit.sv @@
// top level of the request line and header framing parser
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata: req_byte; tlast: end_of_request
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata: result fields; tuser: item_kind;
//                                               tlast: last_of_run
//  cfg       in   cfg_we                        cfg_wdata: max_target_len
//
// one request byte is taken per cycle while s_axis_tready is high; its results
// land in the output queue at the same edge and can leave on the next cycle
// a byte that ends the buffer may yield a byte word and a verdict word, so
// s_axis_tready drops while fewer than two queue slots are free
// reset returns the parser to method matching with max_target_len at 200;
// there is no clearing pass
module http_request_header_parser_unit
#(
    parameter int OUT_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // req_byte
    input  logic        s_axis_tlast,   // end_of_request
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // data_byte, byte_index, method_code, parse_status, header_complete,
    // header_length, zero fill
    output logic [39:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // item_kind
    output logic        m_axis_tlast,   // last_of_run
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);
    import hrp_pkg::*;

    `include "http_request_header_parser_unit_macros.svh"

    logic      in_accept;
    logic      out_accept;
    logic      push0;
    logic      push1;
    logic      room_for_two;
    hrp_item_t item0;
    hrp_item_t item1;
    hrp_item_t head;

    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign out_accept = m_axis_tvalid && m_axis_tready;

    hrp_parse_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_accept (in_accept),
        .in_byte   (s_axis_tdata),
        .in_eor    (s_axis_tlast),
        .push0     (push0),
        .push1     (push1),
        .item0     (item0),
        .item1     (item1)
    );

    hrp_out_fifo #(.DEPTH(OUT_DEPTH)) u_fifo
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push0        (push0),
        .push1        (push1),
        .din0         (item0),
        .din1         (item1),
        .pop          (out_accept),
        .dout         (head),
        .not_empty    (m_axis_tvalid),
        .room_for_two (room_for_two)
    );

    assign s_axis_tready = room_for_two;
    assign m_axis_tdata  = {2'b00, head.header_length, head.header_complete,
                            head.parse_status, head.method_code,
                            head.byte_index, head.data_byte};
    assign m_axis_tuser  = head.item_kind;
    assign m_axis_tlast  = head.last_of_run;

    `HRP_ASSERT_IMPL(a_push_needs_accept, !in_accept, !push0 && !push1, "word queued without input")
    `HRP_ASSERT_IMPL(a_two_words_only_at_end, push1, s_axis_tlast && item1.item_kind == KIND_VERDICT,
                     "second word without end of request")
    `HRP_ASSERT_IMPL(a_last_marks_verdict, m_axis_tvalid,
                     m_axis_tlast == (m_axis_tuser == KIND_VERDICT), "tlast not on verdict word")
    `HRP_ASSERT_NEXT(a_word_held_on_stall, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast),
                     "output word changed while stalled")

endmodule
